FILE: sv/srmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmq_pkg: shared types and constants for the range-minimum store
// Sizes, opcodes, the empty marker and the controller state type.
// ----------------------------------------------------------------------------
package srmq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int MAX_BUCKETS  = 32;

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);      // element address
    localparam int CNT_W  = $clog2(MAX_ELEMENTS) + 1;  // count, positions
    localparam int BKT_W  = $clog2(MAX_BUCKETS);       // bucket address
    localparam int SIDE_W = BKT_W + 1;                 // bucket side, 1..32
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_word;

    localparam t_word EMPTY_MARK = 32'sd1000000006;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;   // unused code, no effect

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOCATE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

FILE: sv/srmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmq_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srmq_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/sqrt_decomposition_range_min.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrt_decomposition_range_min: range-minimum store, sqrt decomposition
// One item at a time: busy stays high until its result strobe (a bad request or
// unknown opcode strobes without raising busy). Receiver cannot stall results.
// Reset (and any count write) runs a clearing pass over every element, busy high.
// ----------------------------------------------------------------------------
module sqrt_decomposition_range_min (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_opcode,
    input  logic [srmq_pkg::IDX_W-1:0]        i_index_start,
    input  logic [srmq_pkg::IDX_W-1:0]        i_index_end,
    input  logic signed [srmq_pkg::DATA_W-1:0] i_new_value,
    // result strobe
    output logic                              o_result_valid,
    output logic signed [srmq_pkg::DATA_W-1:0] o_min_value,
    output logic                              o_bad_request,
    // element_count register write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srmq_pkg::CNT_W-1:0]        i_cfg_data
);

    localparam int IDX_W  = srmq_pkg::IDX_W;
    localparam int CNT_W  = srmq_pkg::CNT_W;
    localparam int BKT_W  = srmq_pkg::BKT_W;
    localparam int SIDE_W = srmq_pkg::SIDE_W;
    localparam int DATA_W = srmq_pkg::DATA_W;
    localparam int SQ_W   = 2 * SIDE_W;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    srmq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;       // element_count, saturated
    logic [SIDE_W-1:0] r_side, n_side;         // bucket side, grown during clear
    logic [IDX_W-1:0]  r_clr_addr, n_clr_addr; // clearing pass pointer
    logic              r_clr_reply, n_clr_reply; // clear came from an opcode
    logic              r_pend, n_pend;         // a RAM read is in flight
    logic              r_res_valid, n_res_valid;

    // Payload / datapath registers (no reset needed)
    logic              r_op_query, n_op_query;
    logic [IDX_W-1:0]  r_start_idx, n_start_idx;
    logic [CNT_W-1:0]  r_last, n_last;         // last element index to cover
    logic [CNT_W-1:0]  r_p, n_p;               // scan position
    logic [CNT_W-1:0]  r_cs, n_cs;             // start of bucket holding r_p
    logic [SIDE_W-1:0] r_b, n_b;               // bucket holding r_p
    logic [BKT_W-1:0]  r_wb_b, n_wb_b;         // bucket refreshed by an update
    logic              r_pend_bmin, n_pend_bmin; // in-flight read is a bucket min
    srmq_pkg::t_word   r_acc, n_acc;
    srmq_pkg::t_word   r_min_value, n_min_value;
    logic              r_bad, n_bad;

    // ------------------------------------------------------------------
    // RAM ports
    // ------------------------------------------------------------------
    logic              elem_we;
    logic [IDX_W-1:0]  elem_waddr;
    srmq_pkg::t_word   elem_wdata;
    logic [DATA_W-1:0] elem_rdata;
    logic              bmin_we;
    logic [BKT_W-1:0]  bmin_waddr;
    srmq_pkg::t_word   bmin_wdata;
    logic [DATA_W-1:0] bmin_rdata;

    srmq_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_raddr (r_p[IDX_W-1:0]),
        .o_rdata (elem_rdata)
    );

    srmq_ram #(
        .ADDR_W (BKT_W),
        .DATA_W (DATA_W)
    ) u_bmin_ram (
        .i_clk   (i_clk),
        .i_we    (bmin_we),
        .i_waddr (bmin_waddr),
        .i_wdata (bmin_wdata),
        .i_raddr (r_b[BKT_W-1:0]),
        .o_rdata (bmin_rdata)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]  side_sq;
    logic [CNT_W-1:0] cs_next;     // start of the following bucket
    logic [CNT_W-1:0] bkt_end;     // last index of the current bucket
    logic [CNT_W-1:0] cnt_last;    // count - 1
    logic [CNT_W-1:0] cfg_count;
    logic             upd_bad;
    logic             qry_bad;
    srmq_pkg::t_word  rd_word;

    assign side_sq   = SQ_W'(r_side) * SQ_W'(r_side);
    assign cs_next   = r_cs + CNT_W'(r_side);
    assign bkt_end   = cs_next - CNT_W'(1);
    assign cnt_last  = r_count - CNT_W'(1);
    assign cfg_count = (i_cfg_data > CNT_W'(srmq_pkg::MAX_ELEMENTS))
                       ? CNT_W'(srmq_pkg::MAX_ELEMENTS) : i_cfg_data;
    assign upd_bad   = ({1'b0, i_index_start} >= r_count);
    assign qry_bad   = upd_bad || ({1'b0, i_index_end} >= r_count)
                       || (i_index_start > i_index_end);
    assign rd_word   = r_pend_bmin ? srmq_pkg::t_word'(bmin_rdata)
                                   : srmq_pkg::t_word'(elem_rdata);

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_side      = r_side;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_pend      = 1'b0;
        n_pend_bmin = r_pend_bmin;
        n_res_valid = 1'b0;
        n_op_query  = r_op_query;
        n_start_idx = r_start_idx;
        n_last      = r_last;
        n_p         = r_p;
        n_cs        = r_cs;
        n_b         = r_b;
        n_wb_b      = r_wb_b;
        n_acc       = r_acc;
        n_min_value = r_min_value;
        n_bad       = r_bad;

        elem_we    = 1'b0;
        elem_waddr = r_clr_addr;
        elem_wdata = srmq_pkg::EMPTY_MARK;
        bmin_we    = 1'b0;
        bmin_waddr = r_clr_addr[BKT_W-1:0];
        bmin_wdata = srmq_pkg::EMPTY_MARK;

        // fold the read issued last cycle
        if (r_pend && (rd_word < r_acc)) begin
            n_acc = rd_word;
        end

        unique case (r_state)
            srmq_pkg::ST_IDLE: begin
                if (start) begin
                    n_start_idx = i_index_start;
                    n_cs        = '0;
                    n_b         = '0;
                    n_min_value = srmq_pkg::EMPTY_MARK;
                    n_bad       = 1'b0;
                    case (i_opcode)
                        srmq_pkg::OP_UPDATE: begin
                            if (upd_bad) begin
                                n_bad       = 1'b1;
                                n_res_valid = 1'b1;
                            end else begin
                                // element written now; the bucket rescan reads it back
                                elem_we    = 1'b1;
                                elem_waddr = i_index_start;
                                elem_wdata = i_new_value;
                                n_op_query = 1'b0;
                                n_acc      = i_new_value;
                                n_state    = srmq_pkg::ST_LOCATE;
                            end
                        end
                        srmq_pkg::OP_QUERY: begin
                            if (qry_bad) begin
                                n_bad       = 1'b1;
                                n_res_valid = 1'b1;
                            end else begin
                                n_op_query = 1'b1;
                                n_last     = {1'b0, i_index_end};
                                n_acc      = srmq_pkg::EMPTY_MARK;
                                n_state    = srmq_pkg::ST_LOCATE;
                            end
                        end
                        srmq_pkg::OP_CLEAR: begin
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = srmq_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_res_valid = 1'b1;   // unknown opcode: no effect
                        end
                    endcase
                end
            end

            srmq_pkg::ST_CLEAR: begin
                elem_we = 1'b1;
                bmin_we = (r_clr_addr < IDX_W'(srmq_pkg::MAX_BUCKETS));
                // bucket side settles long before the pass ends
                if (side_sq < SQ_W'(r_count)) begin
                    n_side = r_side + SIDE_W'(1);
                end
                if (r_clr_addr == IDX_W'(srmq_pkg::MAX_ELEMENTS - 1)) begin
                    n_state = srmq_pkg::ST_IDLE;
                    if (r_clr_reply) begin
                        n_min_value = srmq_pkg::EMPTY_MARK;
                        n_bad       = 1'b0;
                        n_res_valid = 1'b1;
                    end
                end else begin
                    n_clr_addr = r_clr_addr + IDX_W'(1);
                end
            end

            srmq_pkg::ST_LOCATE: begin
                // walk bucket by bucket to the one holding the start index
                if (cs_next <= {1'b0, r_start_idx}) begin
                    n_cs = cs_next;
                    n_b  = r_b + SIDE_W'(1);
                end else begin
                    // a query starts at its first index, an update rescans
                    // its whole bucket
                    n_p    = r_op_query ? {1'b0, r_start_idx} : r_cs;
                    n_wb_b = r_b[BKT_W-1:0];
                    if (!r_op_query) begin
                        n_last = (bkt_end < cnt_last) ? bkt_end : cnt_last;
                    end
                    n_state = srmq_pkg::ST_SCAN;
                end
            end

            srmq_pkg::ST_SCAN: begin
                if (r_p > r_last) begin
                    n_state = srmq_pkg::ST_FINISH;
                end else if (r_op_query && (r_p == r_cs) && (bkt_end <= r_last)) begin
                    // whole bucket inside the range: use its stored minimum
                    n_pend      = 1'b1;
                    n_pend_bmin = 1'b1;
                    n_p         = cs_next;
                    n_cs        = cs_next;
                    n_b         = r_b + SIDE_W'(1);
                end else begin
                    n_pend      = 1'b1;
                    n_pend_bmin = 1'b0;
                    n_p         = r_p + CNT_W'(1);
                    if (r_p == bkt_end) begin
                        n_cs = cs_next;
                        n_b  = r_b + SIDE_W'(1);
                    end
                end
            end

            srmq_pkg::ST_FINISH: begin
                n_bad       = 1'b0;
                n_res_valid = 1'b1;
                if (r_op_query) begin
                    n_min_value = r_acc;
                end else begin
                    bmin_we     = 1'b1;
                    bmin_waddr  = r_wb_b;
                    bmin_wdata  = r_acc;
                    n_min_value = srmq_pkg::EMPTY_MARK;
                end
                n_state = srmq_pkg::ST_IDLE;
            end

            default: begin
                n_state = srmq_pkg::ST_IDLE;
            end
        endcase

        // count write: recompute side and restart the clearing pass
        if (i_cfg_valid) begin
            n_count     = cfg_count;
            n_side      = SIDE_W'(1);
            n_clr_addr  = '0;
            n_clr_reply = 1'b0;
            n_res_valid = 1'b0;
            n_state     = srmq_pkg::ST_CLEAR;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srmq_pkg::ST_CLEAR;
            r_count     <= CNT_W'(srmq_pkg::MAX_ELEMENTS);
            r_side      <= SIDE_W'(1);
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_side      <= n_side;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_query  <= n_op_query;
        r_start_idx <= n_start_idx;
        r_last      <= n_last;
        r_p         <= n_p;
        r_cs        <= n_cs;
        r_b         <= n_b;
        r_wb_b      <= n_wb_b;
        r_pend_bmin <= n_pend_bmin;
        r_acc       <= n_acc;
        r_min_value <= n_min_value;
        r_bad       <= n_bad;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy           = (r_state != srmq_pkg::ST_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_min_value    = r_min_value;
    assign o_bad_request  = r_bad;
    assign o_cfg_ready    = 1'b1;

endmodule
